FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the step pulse frequency ramp top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define SPFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside of reset.
`define SPFR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/spfr_pkg.sv
// Types and constants of the step pulse frequency ramp.
`timescale 1ns / 1ps
`default_nettype none

package spfr_pkg;

    typedef enum logic [1:0] {
        CMD_FORWARD  = 2'd0,
        CMD_BACKWARD = 2'd1,
        CMD_STOP     = 2'd2,
        CMD_TICK     = 2'd3
    } spfr_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIVIDE,
        ST_FINISH
    } spfr_state_t;

    localparam logic [2:0] CFG_TIMER_CLOCK = 3'd0;
    localparam logic [2:0] CFG_MIN_FREQ    = 3'd1;
    localparam logic [2:0] CFG_MAX_FREQ    = 3'd2;
    localparam logic [2:0] CFG_STEP_SIZE   = 3'd3;
    localparam logic [2:0] CFG_MIN_RELOAD  = 3'd4;

    localparam logic [31:0] TIMER_CLOCK_RESET = 32'd240000000;
    localparam logic [15:0] MIN_FREQ_RESET    = 16'd200;
    localparam logic [15:0] MAX_FREQ_RESET    = 16'd20000;
    localparam logic [15:0] STEP_SIZE_RESET   = 16'd50;
    localparam logic [31:0] MIN_RELOAD_RESET  = 32'd10;
    localparam logic [15:0] FREQ_RESET        = 16'd500;

    localparam int unsigned DIV_STEPS = 32;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] target_freq;
    } spfr_in_t;

    typedef struct packed {
        logic [15:0] current_freq;
        logic [31:0] reload_value;
        logic [30:0] compare_value;
        logic        direction;
        logic        output_enabled;
        logic        ramping;
        logic        counter_restart;
    } spfr_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } spfr_div_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/step_pulse_frequency_ramp.sv
// Top level of the step pulse frequency ramp: command handling, ramp state and period result.
`timescale 1ns / 1ps
`default_nettype none

// Each beat on the input channel carries a forward, backward, stop or tick command and yields
// one result beat with the present frequency, the timer reload and compare values and the
// direction, enable, ramping and restart flags. The block holds one beat at a time: a beat
// passes the start, divide and finish states before its result is ready; the serial divider
// forms timer clock over frequency one quotient bit per cycle. The next beat is accepted as
// soon as the result is in the output register, even while it is still stalled.
// Configuration registers may be written whenever no beat is in progress.
module step_pulse_frequency_ramp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire spfr_pkg::spfr_in_t   in_data,
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      spfr_pkg::spfr_out_t  out_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_wr_data
);
    import spfr_pkg::*;

    `include "assert_macros.svh"

    function automatic logic [15:0] clamp_freq(input logic [15:0] f, input logic [15:0] lo,
                                               input logic [15:0] hi);
        logic [15:0] v;
        v = (f < lo) ? lo : f;
        v = (v > hi) ? hi : v;
        return v;
    endfunction

    spfr_state_t      state_reg;
    spfr_state_t      state_next;
    logic [31:0]      timer_clock_reg;
    logic [15:0]      min_freq_reg;
    logic [15:0]      max_freq_reg;
    logic [15:0]      step_size_reg;
    logic [31:0]      min_reload_reg;
    logic [15:0]      present_reg;
    logic [15:0]      present_next;
    logic [15:0]      goal_reg;
    logic [15:0]      goal_next;
    logic             dir_reg;
    logic             dir_next;
    logic             enable_reg;
    logic             enable_next;
    logic             stop_reg;
    logic             stop_next;
    logic             restart_reg;
    logic             restart_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    spfr_out_t        out_data_reg;
    spfr_out_t        out_data_next;
    logic             div_start;
    logic [31:0]      div_quotient;
    spfr_div_status_t div_status;
    logic [15:0]      ramp_diff;
    logic [15:0]      ramp_freq;
    logic [31:0]      quo_dec;
    logic [31:0]      reload;
    logic             out_free;

    spfr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (timer_clock_reg),
        .divisor  (clamp_freq(present_reg, min_freq_reg, max_freq_reg)),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign ramp_diff = (goal_reg > present_reg) ? (goal_reg - present_reg)
                                                : (present_reg - goal_reg);
    assign ramp_freq = (ramp_diff <= step_size_reg) ? goal_reg
                     : (goal_reg > present_reg) ? (present_reg + step_size_reg)
                                                : (present_reg - step_size_reg);

    assign quo_dec  = (div_quotient == '0) ? '0 : (div_quotient - 32'd1);
    assign reload   = (quo_dec < min_reload_reg) ? min_reload_reg : quo_dec;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        present_next   = present_reg;
        goal_next      = goal_reg;
        dir_next       = dir_reg;
        enable_next    = enable_reg;
        stop_next      = stop_reg;
        restart_next   = restart_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    restart_next = 1'b0;
                    unique case (spfr_cmd_t'(in_data.command))
                        CMD_FORWARD, CMD_BACKWARD:
                        begin
                            dir_next    = (spfr_cmd_t'(in_data.command) == CMD_FORWARD);
                            enable_next = 1'b1;
                            stop_next   = 1'b0;
                            goal_next   = clamp_freq(in_data.target_freq, min_freq_reg,
                                                     max_freq_reg);
                        end
                        CMD_STOP:
                        begin
                            goal_next = clamp_freq(min_freq_reg, min_freq_reg, max_freq_reg);
                            stop_next = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            if (present_reg != goal_reg && step_size_reg != '0)
                            begin
                                present_next = ramp_freq;
                                restart_next = 1'b1;
                            end
                            if (stop_reg && present_next == goal_reg)
                            begin
                                enable_next = 1'b0;
                                stop_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.current_freq    = present_reg;
                    out_data_next.reload_value    = reload;
                    out_data_next.compare_value   = enable_reg ? reload[31:1] : '0;
                    out_data_next.direction       = dir_reg;
                    out_data_next.output_enabled  = enable_reg;
                    out_data_next.ramping         = (present_reg != goal_reg);
                    out_data_next.counter_restart = restart_reg;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= FREQ_RESET;
            goal_reg      <= FREQ_RESET;
            dir_reg       <= 1'b0;
            enable_reg    <= 1'b0;
            stop_reg      <= 1'b0;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            present_reg   <= present_next;
            goal_reg      <= goal_next;
            dir_reg       <= dir_next;
            enable_reg    <= enable_next;
            stop_reg      <= stop_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clock_reg <= TIMER_CLOCK_RESET;
            min_freq_reg    <= MIN_FREQ_RESET;
            max_freq_reg    <= MAX_FREQ_RESET;
            step_size_reg   <= STEP_SIZE_RESET;
            min_reload_reg  <= MIN_RELOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TIMER_CLOCK: timer_clock_reg <= cfg_wr_data;
                CFG_MIN_FREQ:    min_freq_reg    <= cfg_wr_data[15:0];
                CFG_MAX_FREQ:    max_freq_reg    <= cfg_wr_data[15:0];
                CFG_STEP_SIZE:   step_size_reg   <= cfg_wr_data[15:0];
                CFG_MIN_RELOAD:  min_reload_reg  <= cfg_wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SPFR_ASSERT(a_done_in_divide, div_status.done |-> (state_reg == ST_DIVIDE),
                 "Divider finished outside the divide state.")
    `SPFR_ASSERT(a_start_when_idle, div_start |-> !div_status.busy,
                 "Divider started while still busy.")
    `SPFR_ASSERT(a_hold_unread,
                 (state_reg == ST_FINISH && out_valid_reg && out_stall) |=> (state_reg == ST_FINISH),
                 "Result written over an untaken beat.")
    `SPFR_ASSERT(a_compare_off,
                 (out_valid_reg && !out_data_reg.output_enabled) |-> (out_data_reg.compare_value == '0),
                 "Compare value nonzero while output is disabled.")

endmodule

`default_nettype wire

FILE: hw/rtl/spfr_divider.sv
// Serial restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module spfr_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [31:0]               dividend,
    input  wire logic [15:0]               divisor,
    output      logic [31:0]               quotient,
    output      spfr_pkg::spfr_div_status_t status
);
    import spfr_pkg::*;

    localparam int unsigned CountWidth = $clog2(DIV_STEPS);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [15:0]           rem_reg;
    logic [15:0]           rem_next;
    logic [31:0]           quo_reg;
    logic [31:0]           quo_next;
    logic [15:0]           divisor_reg;
    logic [15:0]           divisor_next;
    logic [16:0]           trial;
    logic [16:0]           trial_diff;
    logic                  fits;

    assign trial      = {rem_reg, quo_reg[31]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign fits       = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = CountWidth'(DIV_STEPS - 1);
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_diff[15:0] : trial[15:0];
            quo_next = {quo_reg[30:0], fits};
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire
